### rtl/tsft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsft_pkg
// Shared constants and types for the topic subscriber fan-out table.
// ----------------------------------------------------------------------------
package tsft_pkg;

  localparam int MAX_TOPICS = 16;
  localparam int MAX_SUBS   = 8;

  localparam int IDX_W  = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
  localparam int CNT_W  = $clog2(MAX_SUBS + 1);
  localparam int DEPTH  = MAX_TOPICS * MAX_SUBS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int FUNC_W      = 16;
  localparam int TOPIC_W     = 16;
  localparam int IP_W        = 32;
  localparam int PORT_W      = 16;
  localparam int PAYLOAD_W   = 64;
  localparam int STATUS_W    = 3;
  localparam int SUB_TOTAL_W = 4;
  localparam int ADDR_WORD_W = IP_W + PORT_W;

  localparam logic [FUNC_W-1:0] FUNC_SUBSCRIBE = 16'd1;
  localparam logic [FUNC_W-1:0] FUNC_PUBLISH   = 16'd2;

  localparam logic [STATUS_W-1:0] ST_SUBSCRIBED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FORWARD    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SUBS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOPIC_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LIST_FULL  = 3'd4;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [TOPIC_W-1:0] topic;
    logic [CNT_W-1:0]   count;
  } tbl_wr_t;

  typedef struct packed {
    logic             valid;
    logic             match;
    logic [CNT_W-1:0] count;
  } tbl_rd_t;

endpackage
`default_nettype wire

### rtl/topic_subscriber_fanout_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// topic_subscriber_fanout_table
// Publish/subscribe fan-out: subscribe appends a sender to a topic list,
// publish emits one forward word per subscriber (a status word if none).
// ----------------------------------------------------------------------------
// The topic scan checks one entry at a time up to a hit or the last entry,
// then resolves; the result word is registered. A publish then emits one
// forward word per subscriber, each through a subscriber store read and
// then the output register. Busy covers the whole item.
// Unknown types are dropped in the accept cycle. Reset clears the topic
// valid bits and the sequencer; results cannot be stalled by the receiver.
module topic_subscriber_fanout_table
  import tsft_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [FUNC_W-1:0]      func_i,
  input  wire logic [TOPIC_W-1:0]     topic_i,
  input  wire logic [IP_W-1:0]        sender_ip_i,
  input  wire logic [PORT_W-1:0]      sender_port_i,
  input  wire logic [PAYLOAD_W-1:0]   payload_i,
  output logic                        valid_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic [IP_W-1:0]             dest_ip_o,
  output logic [PORT_W-1:0]           dest_port_o,
  output logic [PAYLOAD_W-1:0]        out_payload_o,
  output logic [TOPIC_W-1:0]          out_topic_o,
  output logic [SUB_TOTAL_W-1:0]      sub_total_o,
  output logic                        last_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_READ    = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TOPICS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SUBS);

  logic [2:0]           state_q, state_d;
  logic                 pub_q, pub_d;
  logic [TOPIC_W-1:0]   topic_q, topic_d;
  logic [IP_W-1:0]      ip_q, ip_d;
  logic [PORT_W-1:0]    port_q, port_d;
  logic [PAYLOAD_W-1:0] payload_q, payload_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 hit_q, hit_d;
  logic                 free_q, free_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic                 sel_ok_q, sel_ok_d;
  logic [IDX_W-1:0]     sel_idx_q, sel_idx_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     k_q, k_d;

  logic                   valid_q, valid_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [IP_W-1:0]        dip_q, dip_d;
  logic [PORT_W-1:0]      dport_q, dport_d;
  logic [PAYLOAD_W-1:0]   opl_q, opl_d;
  logic [TOPIC_W-1:0]     otopic_q, otopic_d;
  logic [SUB_TOTAL_W-1:0] total_q, total_d;
  logic                   last_q, last_d;

  tbl_wr_t              tbl_wr;
  tbl_rd_t              tbl_rd;
  logic [IDX_W-1:0]     tbl_idx;
  logic [CNT_W-1:0]     cur_cnt;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ADDR_WORD_W-1:0] ram_rdata;
  logic [ADDR_W-1:0]    row_base;

  assign tbl_idx  = (state_q == S_SCAN) ? idx_q : sel_idx_q;
  assign cur_cnt  = hit_q ? tbl_rd.count : '0;
  assign row_base = ADDR_W'(sel_idx_q) * ADDR_W'(MAX_SUBS);
  assign ram_waddr = row_base + ADDR_W'(cur_cnt);
  assign ram_raddr = row_base + ADDR_W'(k_q);

  tsft_topic_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (tbl_idx),
    .topic_i  (topic_q),
    .wr_i     (tbl_wr),
    .rd_o     (tbl_rd)
  );

  tsft_sub_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({ip_q, port_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    pub_d      = pub_q;
    topic_d    = topic_q;
    ip_d       = ip_q;
    port_d     = port_q;
    payload_d  = payload_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    sel_ok_d   = sel_ok_q;
    sel_idx_d  = sel_idx_q;
    n_d        = n_q;
    k_d        = k_q;

    valid_d  = 1'b0;
    status_d = status_q;
    dip_d    = dip_q;
    dport_d  = dport_q;
    opl_d    = opl_q;
    otopic_d = otopic_q;
    total_d  = total_q;
    last_d   = last_q;

    tbl_wr       = '0;
    tbl_wr.idx   = sel_idx_q;
    tbl_wr.topic = topic_q;
    tbl_wr.count = cur_cnt + CNT_W'(1);
    ram_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start && (func_i == FUNC_SUBSCRIBE || func_i == FUNC_PUBLISH)) begin
          pub_d     = (func_i == FUNC_PUBLISH);
          topic_d   = topic_i;
          ip_d      = sender_ip_i;
          port_d    = sender_port_i;
          payload_d = payload_i;
          idx_d     = '0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tbl_rd.match) begin
          hit_d     = 1'b1;
          sel_ok_d  = 1'b1;
          sel_idx_d = idx_q;
          state_d   = S_RESOLVE;
        end else begin
          if (!tbl_rd.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx_q;
          end
          if (idx_q == LAST_IDX) begin
            hit_d     = 1'b0;
            sel_ok_d  = free_q || !tbl_rd.valid;
            sel_idx_d = free_q ? free_idx_q : idx_q;
            state_d   = S_RESOLVE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      S_RESOLVE: begin
        valid_d  = 1'b1;
        dip_d    = '0;
        dport_d  = '0;
        opl_d    = '0;
        otopic_d = topic_q;
        last_d   = 1'b1;
        state_d  = S_IDLE;
        if (!pub_q) begin
          if (!sel_ok_q) begin
            status_d = ST_TOPIC_FULL;
            total_d  = '0;
          end else if (cur_cnt >= FULL_CNT) begin
            status_d = ST_LIST_FULL;
            total_d  = SUB_TOTAL_W'(cur_cnt);
          end else begin
            status_d  = ST_SUBSCRIBED;
            total_d   = SUB_TOTAL_W'(cur_cnt + CNT_W'(1));
            tbl_wr.en = 1'b1;
            ram_we    = 1'b1;
          end
        end else if (cur_cnt == '0) begin
          status_d = ST_NO_SUBS;
          total_d  = '0;
        end else begin
          valid_d = 1'b0;
          n_d     = cur_cnt;
          k_d     = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        valid_d  = 1'b1;
        status_d = ST_FORWARD;
        dip_d    = ram_rdata[ADDR_WORD_W-1:PORT_W];
        dport_d  = ram_rdata[PORT_W-1:0];
        opl_d    = payload_q;
        otopic_d = topic_q;
        total_d  = SUB_TOTAL_W'(n_q);
        last_d   = (k_q + CNT_W'(1) == n_q);
        k_d      = k_q + CNT_W'(1);
        state_d  = (k_q + CNT_W'(1) == n_q) ? S_IDLE : S_READ;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pub_q      <= pub_d;
    topic_q    <= topic_d;
    ip_q       <= ip_d;
    port_q     <= port_d;
    payload_q  <= payload_d;
    idx_q      <= idx_d;
    hit_q      <= hit_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    sel_ok_q   <= sel_ok_d;
    sel_idx_q  <= sel_idx_d;
    n_q        <= n_d;
    k_q        <= k_d;
    status_q   <= status_d;
    dip_q      <= dip_d;
    dport_q    <= dport_d;
    opl_q      <= opl_d;
    otopic_q   <= otopic_d;
    total_q    <= total_d;
    last_q     <= last_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign dest_ip_o     = dip_q;
  assign dest_port_o   = dport_q;
  assign out_payload_o = opl_q;
  assign out_topic_o   = otopic_q;
  assign sub_total_o   = total_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

### rtl/tsft_topic_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsft_topic_table
// Topic entries with one shared compare against the entry under the index.
// ----------------------------------------------------------------------------
module tsft_topic_table
  import tsft_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [IDX_W-1:0]   rd_idx_i,
  input  wire logic [TOPIC_W-1:0] topic_i,
  input  wire tbl_wr_t            wr_i,
  output tbl_rd_t                 rd_o
);

  logic [MAX_TOPICS-1:0] valid_q;
  logic [TOPIC_W-1:0]    topic_q [MAX_TOPICS];
  logic [CNT_W-1:0]      count_q [MAX_TOPICS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      topic_q[wr_i.idx] <= wr_i.topic;
      count_q[wr_i.idx] <= wr_i.count;
    end
  end

  always_comb begin
    rd_o.valid = valid_q[rd_idx_i];
    rd_o.match = valid_q[rd_idx_i] && (topic_q[rd_idx_i] == topic_i);
    rd_o.count = count_q[rd_idx_i];
  end

endmodule
`default_nettype wire

### rtl/tsft_sub_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsft_sub_ram
// Subscriber address store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tsft_sub_ram
  import tsft_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [ADDR_W-1:0]      waddr_i,
  input  wire logic [ADDR_WORD_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]      raddr_i,
  output logic [ADDR_WORD_W-1:0]      rdata_o
);

  logic [ADDR_WORD_W-1:0] mem_q [DEPTH];
  logic [ADDR_WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the topic subscriber fan-out table. A directed
// table covers empty publishes, ignored types, field extremes, duplicate
// subscribers, a full list and a full topic table. Random traffic, mostly
// on the live topics, follows. Every result word is checked in order, field
// by field, against a local model of the table or the expected row values.
// ----------------------------------------------------------------------------
module tb;
  import tsft_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_IDLE = 16'h0000;
  localparam logic [FUNC_W-1:0] FUNC_JUNK = 16'hFFFF;
  localparam int N_ROWS     = 14;
  localparam int N_RANDOM   = 112;
  localparam int TAIL_WAIT  = 64;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [TOPIC_W-1:0]   topic;
    logic [IP_W-1:0]      ip;
    logic [PORT_W-1:0]    port;
    logic [PAYLOAD_W-1:0] payload;
  } msg_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [IP_W-1:0]        ip;
    logic [PORT_W-1:0]      port;
    logic [PAYLOAD_W-1:0]   payload;
    logic [TOPIC_W-1:0]     topic;
    logic [SUB_TOTAL_W-1:0] total;
    logic                   last;
  } fanout_word_t;

  // span repeats a row; stride steps topic, ip and port on each repeat
  typedef struct packed {
    msg_t                   msg;
    logic [7:0]             span;
    logic                   stride;
    logic                   fixed;
    logic [STATUS_W-1:0]    status;
    logic [SUB_TOTAL_W-1:0] total;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [FUNC_W-1:0]      func_i;
  logic [TOPIC_W-1:0]     topic_i;
  logic [IP_W-1:0]        sender_ip_i;
  logic [PORT_W-1:0]      sender_port_i;
  logic [PAYLOAD_W-1:0]   payload_i;
  logic                   valid_o;
  logic [STATUS_W-1:0]    status_o;
  logic [IP_W-1:0]        dest_ip_o;
  logic [PORT_W-1:0]      dest_port_o;
  logic [PAYLOAD_W-1:0]   out_payload_o;
  logic [TOPIC_W-1:0]     out_topic_o;
  logic [SUB_TOTAL_W-1:0] sub_total_o;
  logic                   last_o;

  topic_subscriber_fanout_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .topic_i       (topic_i),
    .sender_ip_i   (sender_ip_i),
    .sender_port_i (sender_port_i),
    .payload_i     (payload_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .dest_ip_o     (dest_ip_o),
    .dest_port_o   (dest_port_o),
    .out_payload_o (out_payload_o),
    .out_topic_o   (out_topic_o),
    .sub_total_o   (sub_total_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // local copy of the table
  bit                     tbl_live  [MAX_TOPICS];
  logic [TOPIC_W-1:0]     tbl_topic [MAX_TOPICS];
  int unsigned            tbl_count [MAX_TOPICS];
  logic [ADDR_WORD_W-1:0] sub_store [DEPTH];

  fanout_word_t fresh_q[$];
  fanout_word_t pending_q[$];
  int           mismatches = 0;
  int           burst_left = 0;

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void forecast_fanout(input msg_t m);
    int           e;
    int unsigned  n;
    int unsigned  k;
    fanout_word_t w;
    fresh_q.delete();
    w       = '0;
    w.topic = m.topic;
    w.last  = 1'b1;
    e       = -1;
    for (k = 0; k < MAX_TOPICS; k++) begin
      if (e < 0 && tbl_live[k] && tbl_topic[k] == m.topic) e = k;
    end
    if (m.func == FUNC_SUBSCRIBE) begin
      if (e < 0) begin
        for (k = 0; k < MAX_TOPICS; k++) begin
          if (e < 0 && !tbl_live[k]) e = k;
        end
        if (e < 0) begin
          w.status = ST_TOPIC_FULL;
          fresh_q  = {fresh_q, w};
          return;
        end
        tbl_live[e]  = 1'b1;
        tbl_topic[e] = m.topic;
        tbl_count[e] = 0;
      end
      n = tbl_count[e];
      if (n >= MAX_SUBS) begin
        w.status = ST_LIST_FULL;
        w.total  = SUB_TOTAL_W'(n);
      end else begin
        sub_store[e * MAX_SUBS + n] = {m.ip, m.port};
        tbl_count[e] = n + 1;
        w.status = ST_SUBSCRIBED;
        w.total  = SUB_TOTAL_W'(n + 1);
      end
      fresh_q = {fresh_q, w};
    end else if (m.func == FUNC_PUBLISH) begin
      n = (e < 0) ? 0 : tbl_count[e];
      if (n > MAX_SUBS) n = MAX_SUBS;
      if (n == 0) begin
        w.status = ST_NO_SUBS;
        fresh_q  = {fresh_q, w};
      end else begin
        for (k = 0; k < n; k++) begin
          w.status  = ST_FORWARD;
          w.ip      = sub_store[e * MAX_SUBS + k][ADDR_WORD_W-1:PORT_W];
          w.port    = sub_store[e * MAX_SUBS + k][PORT_W-1:0];
          w.payload = m.payload;
          w.total   = SUB_TOTAL_W'(n);
          w.last    = (k + 1 == n);
          fresh_q   = {fresh_q, w};
        end
      end
    end
  endfunction

  // returns at the edge where the word was taken
  task automatic send_word(input msg_t m);
    start         <= 1'b1;
    func_i        <= m.func;
    topic_i       <= m.topic;
    sender_ip_i   <= m.ip;
    sender_port_i <= m.port;
    payload_i     <= m.payload;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    forecast_fanout(m);
  endtask

  task automatic sender_gap();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    fanout_word_t want;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word status %0d topic %h", status_o, out_topic_o));
      end else begin
        want = pending_q.pop_front();
        if (status_o !== want.status)
          report($sformatf("status %0d, want %0d", status_o, want.status));
        if (dest_ip_o !== want.ip)
          report($sformatf("dest_ip %h, want %h", dest_ip_o, want.ip));
        if (dest_port_o !== want.port)
          report($sformatf("dest_port %h, want %h", dest_port_o, want.port));
        if (out_payload_o !== want.payload)
          report($sformatf("payload %h, want %h", out_payload_o, want.payload));
        if (out_topic_o !== want.topic)
          report($sformatf("topic %h, want %h", out_topic_o, want.topic));
        if (sub_total_o !== want.total)
          report($sformatf("sub_total %0d, want %0d", sub_total_o, want.total));
        if (last_o !== want.last)
          report($sformatf("last %b, want %b", last_o, want.last));
      end
    end
  end

  initial begin : stimulus
    plan_row_t    plan [N_ROWS];
    msg_t         m;
    fanout_word_t w;
    int           r;
    int           k;
    int           sent;
    int           pick;
    plan = '{
      '{'{FUNC_PUBLISH,   16'h0000, 32'h0000_0000, 16'h0000, 64'h0},
        8'd1, 1'b0, 1'b1, ST_NO_SUBS, 4'd0},
      '{'{FUNC_IDLE,      16'h1234, 32'h1111_1111, 16'h2222, 64'h5},
        8'd1, 1'b0, 1'b0, ST_SUBSCRIBED, 4'd0},
      '{'{FUNC_JUNK,      16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '1},
        8'd1, 1'b0, 1'b0, ST_SUBSCRIBED, 4'd0},
      '{'{FUNC_SUBSCRIBE, 16'h0000, 32'h0000_0000, 16'h0000, 64'h0},
        8'd1, 1'b0, 1'b1, ST_SUBSCRIBED, 4'd1},
      '{'{FUNC_SUBSCRIBE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '1},
        8'd1, 1'b0, 1'b1, ST_SUBSCRIBED, 4'd1},
      '{'{FUNC_SUBSCRIBE, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 64'h0},
        8'd1, 1'b0, 1'b1, ST_SUBSCRIBED, 4'd2},
      // same sender again: no duplicate check
      '{'{FUNC_SUBSCRIBE, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 64'h0},
        8'd1, 1'b0, 1'b1, ST_SUBSCRIBED, 4'd3},
      '{'{FUNC_SUBSCRIBE, 16'h0000, 32'h0A00_0001, 16'h1000, 64'h0},
        8'd5, 1'b0, 1'b0, ST_SUBSCRIBED, 4'd0},
      '{'{FUNC_SUBSCRIBE, 16'h0000, 32'hC0A8_0001, 16'h0050, 64'h0},
        8'd1, 1'b0, 1'b1, ST_LIST_FULL, 4'd8},
      '{'{FUNC_PUBLISH,   16'h0000, 32'h0000_0000, 16'h0000, '1},
        8'd1, 1'b0, 1'b0, ST_SUBSCRIBED, 4'd0},
      '{'{FUNC_PUBLISH,   16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 64'h0},
        8'd1, 1'b0, 1'b0, ST_SUBSCRIBED, 4'd0},
      // fills the remaining topic entries
      '{'{FUNC_SUBSCRIBE, 16'h0100, 32'h0A00_0100, 16'h2000, 64'h0},
        8'd14, 1'b1, 1'b0, ST_SUBSCRIBED, 4'd0},
      '{'{FUNC_SUBSCRIBE, 16'h8000, 32'h0A00_0200, 16'h3000, 64'h0},
        8'd1, 1'b0, 1'b1, ST_TOPIC_FULL, 4'd0},
      '{'{FUNC_PUBLISH,   16'h8000, 32'h0000_0000, 16'h0000, 64'h0},
        8'd1, 1'b0, 1'b1, ST_NO_SUBS, 4'd0}
    };

    rst_ni        <= 1'b0;
    start         <= 1'b0;
    func_i        <= '0;
    topic_i       <= '0;
    sender_ip_i   <= '0;
    sender_port_i <= '0;
    payload_i     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < N_ROWS; r++) begin
      for (k = 0; k < plan[r].span; k++) begin
        m = plan[r].msg;
        if (plan[r].stride) begin
          m.topic = m.topic + TOPIC_W'(k);
          m.ip    = m.ip + IP_W'(k);
          m.port  = m.port + PORT_W'(k);
        end
        sender_gap();
        send_word(m);
        if (plan[r].fixed) begin
          w         = '0;
          w.status  = plan[r].status;
          w.topic   = m.topic;
          w.total   = plan[r].total;
          w.last    = 1'b1;
          pending_q = {pending_q, w};
        end else begin
          pending_q = {pending_q, fresh_q};
        end
      end
    end
    drain();

    sent = 0;
    while (sent < N_RANDOM) begin
      m.ip      = $urandom;
      m.port    = PORT_W'($urandom);
      m.payload = {$urandom, $urandom};
      pick      = $urandom_range(0, MAX_TOPICS - 1);
      m.topic   = tbl_live[pick] ? tbl_topic[pick] : TOPIC_W'($urandom);
      r         = $urandom_range(0, 99);
      if (r < 40) begin
        m.func = FUNC_SUBSCRIBE;
      end else if (r < 72) begin
        m.func = FUNC_PUBLISH;
      end else if (r < 80) begin
        m.func  = FUNC_SUBSCRIBE;
        m.topic = TOPIC_W'($urandom);
      end else if (r < 86) begin
        m.func  = FUNC_PUBLISH;
        m.topic = TOPIC_W'($urandom);
      end else if (r < 93) begin
        m.func = FUNC_W'($urandom);
      end else begin
        // near miss on a valid type
        m.func = (r[0] ? FUNC_SUBSCRIBE : FUNC_PUBLISH) ^ (16'h1 << $urandom_range(2, 15));
      end
      sender_gap();
      send_word(m);
      pending_q = {pending_q, fresh_q};
      if (m.func == FUNC_SUBSCRIBE || m.func == FUNC_PUBLISH) begin
        sent++;
        if (sent == N_RANDOM / 2) drain();
      end
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
